// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/nasvs_pkg.sv -----
// types and constants of the steal victim selector
package nasvs_pkg;

	localparam int THIEF_W     = 4;
	localparam int THIEF_SLOTS = 16;
	localparam int BUSY_W      = 16;
	localparam int ROT_W       = 32;
	localparam int ROT_SHIFT   = 8;
	localparam int DIV_W       = ROT_W - ROT_SHIFT;
	localparam int WIU_W       = 5;
	localparam int MAP_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [ROT_W-1:0] GOLDEN     = 32'h9E37_79B9;
	localparam logic [WIU_W-1:0] WIU_RESET  = 5'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WORKERS    = 2'd0,
		CFG_NODE_AWARE = 2'd1,
		CFG_NODE_MAP   = 2'd2
	} cfg_idx_t;

	// access to the rotation counter memory
	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic [THIEF_W-1:0] addr;
		logic [ROT_W-1:0]   wdata;
	} rot_req_t;

endpackage

// ----- hw/rtl/nasvs_rot_mem.sv -----
// per-thief rotation counter memory with valid bits standing for the reset value
module nasvs_rot_mem (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nasvs_pkg::rot_req_t                 req,
	output logic [nasvs_pkg::ROT_W-1:0]         rdata
);
	import nasvs_pkg::*;

	logic [ROT_W-1:0]       mem [THIEF_SLOTS];
	logic [THIEF_SLOTS-1:0] valid_q;
	logic [ROT_W-1:0]       rd_q;
	logic                   rvalid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvalid_q <= valid_q[req.addr];
			end
		end
	end

	// never-written entry reads as the golden constant
	assign rdata = rvalid_q ? rd_q : GOLDEN;

endmodule

// ----- hw/rtl/nasvs_mod.sv -----
// bit-serial remainder of the rotated counter by the worker count
module nasvs_mod #(
	parameter int NW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nasvs_pkg::DIV_W-1:0]   dividend,
	input  logic [NW-1:0]                 divisor,
	output logic                          done,
	output logic [NW-1:0]                 rem
);
	import nasvs_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DIV_W-1:0] dvd_q;
	logic [NW-1:0]    rem_q;
	logic [NW:0]      trial;
	logic [NW:0]      rem_nxt;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial   = {rem_q, dvd_q[DIV_W-1]};
		rem_nxt = (trial >= {1'b0, divisor}) ? (trial - {1'b0, divisor}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= dvd_q << 1;
			rem_q <= rem_nxt[NW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ----- hw/rtl/nasvs_scan.sv -----
// two-tier circular victim search over the busy workers
module nasvs_scan #(
	parameter int NODE_BITS   = 2,
	parameter int NW          = 5,
	parameter int SW          = 4
) (
	input  logic                            clk,
	input  logic                            go,
	input  logic [NW-1:0]                   n,
	input  logic [SW-1:0]                   start,
	input  logic [nasvs_pkg::THIEF_W-1:0]   thief,
	input  logic [nasvs_pkg::BUSY_W-1:0]    busy,
	input  logic                            aware,
	input  logic [nasvs_pkg::MAP_W-1:0]     node_map,
	output logic                            found,
	output logic [nasvs_pkg::THIEF_W-1:0]   victim,
	output logic                            near
);
	import nasvs_pkg::*;

	logic [NODE_BITS-1:0] nodes [BUSY_W];
	logic [NODE_BITS-1:0] my_node;
	logic [BUSY_W-1:0]    any_m;
	logic [BUSY_W-1:0]    near_m;
	logic [BUSY_W-1:0]    ge_m;
	logic [THIEF_W:0]     near_sel;
	logic [THIEF_W:0]     any_sel;
	logic                 found_q;
	logic [THIEF_W-1:0]   victim_q;
	logic                 near_q;

	// lowest set bit at or after the start point, else lowest overall
	function automatic logic [THIEF_W:0] pick(input logic [BUSY_W-1:0] m,
						  input logic [BUSY_W-1:0] ge);
		logic [THIEF_W:0] hi;
		logic [THIEF_W:0] lo;
		hi = '0;
		lo = '0;
		for (int w = BUSY_W - 1; w >= 0; w--) begin
			if (m[w] && ge[w]) begin
				hi = {1'b1, THIEF_W'(w)};
			end
			if (m[w]) begin
				lo = {1'b1, THIEF_W'(w)};
			end
		end
		return hi[THIEF_W] ? hi : lo;
	endfunction

	always_comb begin
		for (int w = 0; w < BUSY_W; w++) begin
			// node field past the top of the map counts as node 0
			if (w * NODE_BITS >= MAP_W) begin
				nodes[w] = '0;
			end else begin
				nodes[w] = NODE_BITS'(node_map >> (w * NODE_BITS));
			end
		end
		my_node = nodes[thief];
		for (int w = 0; w < BUSY_W; w++) begin
			any_m[w]  = busy[w] && (8'(w) < 8'(n)) && (THIEF_W'(w) != thief);
			near_m[w] = any_m[w] && (!aware || (nodes[w] == my_node));
			ge_m[w]   = (8'(w) >= 8'(start));
		end
		near_sel = pick(near_m, ge_m);
		any_sel  = pick(any_m, ge_m);
	end

	always_ff @(posedge clk) begin
		if (go) begin
			if (near_sel[THIEF_W]) begin
				found_q  <= 1'b1;
				victim_q <= near_sel[THIEF_W-1:0];
				near_q   <= 1'b1;
			end else if (any_sel[THIEF_W]) begin
				found_q  <= 1'b1;
				victim_q <= any_sel[THIEF_W-1:0];
				near_q   <= 1'b0;
			end else begin
				found_q  <= 1'b0;
				victim_q <= '0;
				near_q   <= 1'b0;
			end
		end
	end

	assign found  = found_q;
	assign victim = victim_q;
	assign near   = near_q;

endmodule

// ----- hw/rtl/numa_aware_steal_victim_select.sv -----
// top level of the two-tier numa-aware steal victim selector
// One request at a time. A request with more than one worker in use reads its rotation
// counter from the memory, then runs the 24-step bit-serial remainder of rotation bits
// 31..8 by the worker count, the search and the output register; the write-back overlaps
// the start of the remainder. The result waits in the final state until the output
// register is free, and the next request can be accepted once it is loaded there. With
// one worker or fewer the request goes straight to the final state and no counter moves.
// Rotation counters live in a 16-entry memory with one read and one write port; a valid
// bit per entry makes a never-written counter read as the golden constant, so there is no
// clearing pass after reset. A new request may be accepted while the previous result still
// waits on the output register. Configuration writes take effect at once and are meant for
// times when no request is in flight.
module numa_aware_steal_victim_select #(
	parameter int MAX_WORKERS = 16,
	parameter int NODE_BITS   = 2
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [nasvs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [nasvs_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [nasvs_pkg::THIEF_W-1:0]       thief,
	input  logic [nasvs_pkg::BUSY_W-1:0]        busy_mask,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                found,
	output logic [nasvs_pkg::THIEF_W-1:0]       victim,
	output logic                                near
);
	import nasvs_pkg::*;

	// worker count width and start point width
	localparam int NW = $clog2(MAX_WORKERS + 1);
	localparam int SW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [WIU_W-1:0]   workers_q;
	logic               aware_q;
	logic [MAP_W-1:0]   node_map_q;

	logic [THIEF_W-1:0] thief_q;
	logic [BUSY_W-1:0]  busy_q;
	logic [NW-1:0]      n_q;
	logic               none_q;

	logic               out_valid_q;
	logic               found_q;
	logic [THIEF_W-1:0] victim_q;
	logic               near_q;

	logic [7:0]         wiu_ext;
	logic [7:0]         max_ext;
	logic [NW-1:0]      n_eff;
	logic               too_few;
	logic               accept;
	logic               out_free;
	logic               load_out;

	rot_req_t           rot_req;
	logic [ROT_W-1:0]   rot_rdata;
	logic [ROT_W-1:0]   rot_new;

	logic               div_done;
	logic [NW-1:0]      div_rem;

	logic               scan_found;
	logic [THIEF_W-1:0] scan_victim;
	logic               scan_near;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			workers_q  <= WIU_RESET;
			aware_q    <= 1'b1;
			node_map_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WORKERS:    workers_q  <= cfg_data[WIU_W-1:0];
				CFG_NODE_AWARE: aware_q    <= cfg_data[0];
				CFG_NODE_MAP:   node_map_q <= cfg_data[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	// worker count clamped to the hardware limit
	always_comb begin
		wiu_ext = 8'(workers_q);
		max_ext = 8'(MAX_WORKERS);
		n_eff   = NW'((wiu_ext > max_ext) ? max_ext : wiu_ext);
		too_few = (n_eff < NW'(2));
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	// a finished result moves into the output register
	assign load_out = (state_q == ST_FIN) && out_free;

	// advanced counter, written back the cycle after the read
	assign rot_new = rot_rdata + GOLDEN;

	always_comb begin
		rot_req       = '0;
		rot_req.wdata = rot_new;
		if (state_q == ST_IDLE) begin
			rot_req.rd_en = accept && !too_few;
			rot_req.addr  = thief;
		end else begin
			rot_req.wr_en = (state_q == ST_UPD);
			rot_req.addr  = thief_q;
		end
	end

	// request fields held for the whole search
	always_ff @(posedge clk) begin
		if (accept) begin
			thief_q <= thief;
			busy_q  <= busy_mask;
			n_q     <= n_eff;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			none_q      <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			victim_q    <= '0;
			near_q      <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						none_q  <= too_few;
						state_q <= too_few ? ST_FIN : ST_UPD;
					end
				end
				ST_UPD: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						found_q     <= none_q ? 1'b0 : scan_found;
						victim_q    <= none_q ? '0 : scan_victim;
						near_q      <= none_q ? 1'b0 : scan_near;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	nasvs_rot_mem u_rot_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rot_req),
		.rdata  (rot_rdata)
	);

	// start point = rotation bits 31..8 modulo the worker count
	nasvs_mod #(
		.NW (NW)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_UPD),
		.dividend (rot_new[ROT_W-1:ROT_SHIFT]),
		.divisor  (n_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	nasvs_scan #(
		.NODE_BITS   (NODE_BITS),
		.NW          (NW),
		.SW          (SW)
	) u_scan (
		.clk      (clk),
		.go       (div_done),
		.n        (n_q),
		.start    (div_rem[SW-1:0]),
		.thief    (thief_q),
		.busy     (busy_q),
		.aware    (aware_q),
		.node_map (node_map_q),
		.found    (scan_found),
		.victim   (scan_victim),
		.near     (scan_near)
	);

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign victim    = victim_q;
	assign near      = near_q;

endmodule

// ----- hw/rtl/nasvs_chk.sv -----
// port-level checker for the steal victim selector and its bind
`include "assert_macros.svh"

module nasvs_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            found,
	input logic [nasvs_pkg::THIEF_W-1:0]   victim,
	input logic                            near
);
	import nasvs_pkg::*;

	// a waiting result holds still
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(found) && $stable(victim) && $stable(near))

	// an empty result carries no victim
	`ASSERT_IMPL(a_none_zero, clk, arst_n, out_valid && !found, victim == '0 && !near)

	// near only for a found victim
	`ASSERT_IMPL(a_near_found, clk, arst_n, out_valid && near, found)

	// one request at a time: busy right after acceptance
	`ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind numa_aware_steal_victim_select nasvs_chk u_nasvs_chk (.*);
